// File: hw/rtl/bse_pkg.sv
// Package with the shared widths, types and sequencer states of the beta-skeleton edge filter.
`timescale 1ns / 1ps
package bse_pkg;

    localparam int MAX_CANDIDATES = 64;
    localparam int COORD_BITS     = 24;
    localparam int DIST_W         = 25;
    localparam int IDX_W          = 32;
    localparam int HB_W           = 16;
    localparam int HB_FRAC        = 15;
    localparam logic [HB_W-1:0] HB_RESET = 16'h8000;

    localparam int SLOT_W = $clog2(MAX_CANDIDATES);
    localparam int CNT_W  = SLOT_W + 1;

    // Offset arithmetic widths.
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int H_W      = DIFF_W + HB_W + 1;
    localparam int OFF_W    = H_W + 1;
    localparam int HD_W     = HB_W + DIST_W;
    localparam int MSRC_W   = (OFF_W > HD_W) ? OFF_W : HD_W;
    localparam int HALF_W   = (MSRC_W + 1) / 2;
    localparam int MAG_W    = 2 * HALF_W;
    localparam int PROD_W   = 2 * HALF_W;
    localparam int ACC_W    = 2 * MAG_W + 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [DIST_W-1:0]            d_val;
    } stored_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
        logic [IDX_W-1:0]             cid;
        stored_t                      cand;
        logic [IDX_W-1:0]             idx;
        logic [SLOT_W-1:0]            slot;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_HMUL,
        B_RAD,
        B_READ,
        B_WAIT,
        B_SQ,
        B_CHECK,
        B_STORE,
        B_OUT
    } back_state_t;

endpackage

// File: hw/rtl/bse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/bse_front.sv
// Front end: accepts items, tracks the query and classifies candidates into test jobs.
`timescale 1ns / 1ps
module bse_front
    import bse_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  logic [DIST_W-1:0]            distance,
    input  logic [IDX_W-1:0]             point_index,
    input  logic [DIST_W-1:0]            search_radius,
    input  q_status_t                    q_status,
    output logic                         push,
    output job_t                         push_job
);

    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, cz_reg;
    logic [IDX_W-1:0]             cid_reg;
    logic [DIST_W-1:0]            radius_reg;
    logic                         past_reg;
    logic [CNT_W-1:0]             count_reg;
    logic                         accept;
    logic                         live;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // A candidate is worth testing only inside the radius and while the buffer has room.
    assign live = kind && !past_reg && (distance <= radius_reg)
                  && (count_reg != CNT_W'(MAX_CANDIDATES));
    assign push = accept && live;

    always_comb
    begin
        push_job.cx         = cx_reg;
        push_job.cy         = cy_reg;
        push_job.cz         = cz_reg;
        push_job.cid        = cid_reg;
        push_job.cand.x     = pos_x;
        push_job.cand.y     = pos_y;
        push_job.cand.z     = pos_z;
        push_job.cand.d_val = distance;
        push_job.idx        = point_index;
        push_job.slot       = count_reg[SLOT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            cid_reg    <= '0;
            radius_reg <= '0;
            past_reg   <= 1'b1;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            if (!kind)
            begin
                cx_reg     <= pos_x;
                cy_reg     <= pos_y;
                cz_reg     <= pos_z;
                cid_reg    <= point_index;
                radius_reg <= search_radius;
                past_reg   <= 1'b0;
                count_reg  <= '0;
            end
            else if (!past_reg && (distance > radius_reg))
            begin
                past_reg <= 1'b1;
            end
            else if (live)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/bse_queue.sv
// Two-entry job queue between the front end and the lune tester.
`timescale 1ns / 1ps
module bse_queue
    import bse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      pop_job,
    output q_status_t status
);

    job_t       mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign status.full  = (cnt_reg == 2'd2);
    assign status.empty = (cnt_reg == 2'd0);
    assign pop_job      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: hw/rtl/bse_back.sv
// Lune tester: scans the stored nearer candidates with one shared squaring multiplier.
`timescale 1ns / 1ps
module bse_back
    import bse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [HB_W-1:0]  half_beta,
    input  q_status_t        q_status,
    input  job_t             pop_job,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [IDX_W-1:0] query_index,
    output logic [IDX_W-1:0] neighbour_index
);

    back_state_t state_reg, state_next;

    job_t                     job_reg;
    logic signed [H_W-1:0]    h_reg [3];
    logic [MAG_W-1:0]         mag_reg;
    logic [ACC_W-1:0]         rad_reg, s1_reg, s2_reg;
    logic [SLOT_W-1:0]        k_reg;
    logic [1:0]               ax_reg;
    logic [1:0]               part_reg;
    logic [2:0]               term_reg;
    logic                     blocked_reg;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         qidx_reg, nidx_reg;

    stored_t                  rd_data;
    logic                     ram_re, ram_we;

    logic signed [COORD_BITS-1:0] cen [3];
    logic signed [COORD_BITS-1:0] cnd [3];
    logic signed [COORD_BITS-1:0] pk  [3];
    logic signed [DIFF_W-1:0]     dj;
    logic signed [H_W-1:0]        h_prod;
    logic [HD_W-1:0]              hd;
    logic [1:0]                   axis;
    logic signed [COORD_BITS-1:0] base;
    logic signed [DIFF_W-1:0]     dk;
    logic signed [OFF_W-1:0]      shifted, hsel, off;
    logic [OFF_W-1:0]             off_mag;
    logic [HALF_W-1:0]            op_a, op_b;
    logic [PROD_W-1:0]            prod;
    logic [ACC_W-1:0]             addend;
    logic                         last_part;
    logic                         in1, in2;

    assign cen = '{job_reg.cx, job_reg.cy, job_reg.cz};
    assign cnd = '{job_reg.cand.x, job_reg.cand.y, job_reg.cand.z};
    assign pk  = '{rd_data.x, rd_data.y, rd_data.z};

    // Per-candidate terms: hb*(Pj-Pi) per axis and hb*d.
    assign dj     = DIFF_W'(cnd[ax_reg]) - DIFF_W'(cen[ax_reg]);
    assign h_prod = $signed({1'b0, half_beta}) * dj;
    assign hd     = half_beta * job_reg.cand.d_val;

    // Offsets of the stored point to the two sphere centres, scaled by 2^15.
    always_comb
    begin
        axis    = (term_reg < 3'd3) ? term_reg[1:0] : 2'(term_reg - 3'd3);
        base    = (term_reg < 3'd3) ? cen[axis] : cnd[axis];
        dk      = DIFF_W'(pk[axis]) - DIFF_W'(base);
        shifted = OFF_W'(dk) <<< HB_FRAC;
        hsel    = OFF_W'(h_reg[axis]);
        off     = (term_reg < 3'd3) ? (shifted - hsel) : (shifted + hsel);
        off_mag = off[OFF_W-1] ? OFF_W'(-off) : OFF_W'(off);
    end

    // Square of mag_reg from three half-width partial products.
    always_comb
    begin
        op_a = mag_reg[HALF_W-1:0];
        op_b = mag_reg[HALF_W-1:0];
        case (part_reg)
            2'd2:    op_a = mag_reg[MAG_W-1:HALF_W];
            2'd3:
            begin
                op_a = mag_reg[MAG_W-1:HALF_W];
                op_b = mag_reg[MAG_W-1:HALF_W];
            end
            default: op_a = mag_reg[HALF_W-1:0];
        endcase
        prod = op_a * op_b;
        case (part_reg)
            2'd2:    addend = ACC_W'(prod) << (HALF_W + 1);
            2'd3:    addend = ACC_W'(prod) << (2 * HALF_W);
            default: addend = ACC_W'(prod);
        endcase
    end

    assign last_part = (part_reg == 2'd3);
    assign in1       = s1_reg < rad_reg;
    assign in2       = s2_reg < rad_reg;

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    state_next = B_HMUL;
                end
            end
            B_HMUL:
            begin
                if (ax_reg == 2'd2)
                begin
                    state_next = B_RAD;
                end
            end
            B_RAD:
            begin
                if (last_part)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                if (k_reg == job_reg.slot)
                begin
                    state_next = B_STORE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = B_WAIT;
                end
            end
            B_WAIT:
            begin
                state_next = (rd_data.d_val >= job_reg.cand.d_val) ? B_STORE : B_SQ;
            end
            B_SQ:
            begin
                if (last_part && (term_reg == 3'd5))
                begin
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                state_next = (in1 && in2) ? B_STORE : B_READ;
            end
            B_STORE:
            begin
                ram_we     = 1'b1;
                state_next = blocked_reg ? B_IDLE : B_OUT;
            end
            B_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_OUT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                job_reg     <= pop_job;
                ax_reg      <= 2'd0;
                part_reg    <= 2'd0;
                k_reg       <= '0;
                blocked_reg <= 1'b0;
                rad_reg     <= '0;
            end
            B_HMUL:
            begin
                h_reg[ax_reg] <= h_prod;
                ax_reg        <= ax_reg + 2'd1;
            end
            B_RAD:
            begin
                if (part_reg == 2'd0)
                begin
                    mag_reg <= MAG_W'(hd);
                end
                else
                begin
                    rad_reg <= rad_reg + addend;
                end
                part_reg <= part_reg + 2'd1;
            end
            B_WAIT:
            begin
                term_reg <= 3'd0;
                part_reg <= 2'd0;
                s1_reg   <= '0;
                s2_reg   <= '0;
            end
            B_SQ:
            begin
                if (part_reg == 2'd0)
                begin
                    mag_reg <= MAG_W'(off_mag);
                end
                else if (term_reg < 3'd3)
                begin
                    s1_reg <= s1_reg + addend;
                end
                else
                begin
                    s2_reg <= s2_reg + addend;
                end
                part_reg <= part_reg + 2'd1;
                if (last_part)
                begin
                    term_reg <= term_reg + 3'd1;
                end
            end
            B_CHECK:
            begin
                if (in1 && in2)
                begin
                    blocked_reg <= 1'b1;
                end
                k_reg <= k_reg + SLOT_W'(1);
            end
            B_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    qidx_reg <= job_reg.cid;
                    nidx_reg <= job_reg.idx;
                end
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    bse_ram #(
        .WIDTH ($bits(stored_t)),
        .DEPTH (MAX_CANDIDATES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (job_reg.slot),
        .wdata (job_reg.cand),
        .re    (ram_re),
        .raddr (k_reg),
        .rdata (rd_data)
    );

    assign out_valid       = out_valid_reg;
    assign query_index     = qidx_reg;
    assign neighbour_index = nidx_reg;

endmodule

// File: hw/rtl/beta_skeleton_edge_filter.sv
// Top level of the lune-based beta-skeleton edge filter.
//
//  Channel   Direction  Signals                                   Moves
//  input     in         in_valid, in_ready, kind .. search_radius  one query or candidate
//  output    out        out_valid, out_ready, query_index, ..      one accepted edge
//  config    in         cfg_we, cfg_wdata                          half_beta, Q1.15
//
// A query or a dropped candidate is handled by the front end alone. A candidate that
// needs testing is queued and handled by the lune tester: a pop, setup of the hb*(Pj-Pi)
// products and the squared radius, then, in slot order until one blocks or is not nearer,
// for each stored nearer candidate k a RAM read, six axis terms through the shared squaring
// multiplier and a check, then a final read check, a store and an output step. A blocked
// candidate skips the output step. Reset clears the sequencer, the output valid, the
// front-end query state and the queue pointers; no clearing pass, stored entries are only
// read below the fill count. The two-entry queue lets the front accept transfers while the
// tester is busy, and the output register holds a result while out_ready is low.
`timescale 1ns / 1ps
module beta_skeleton_edge_filter
    import bse_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  logic [DIST_W-1:0]            distance,
    input  logic [IDX_W-1:0]             point_index,
    input  logic [DIST_W-1:0]            search_radius,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [IDX_W-1:0]             query_index,
    output logic [IDX_W-1:0]             neighbour_index,
    input  logic                         cfg_we,
    input  logic [HB_W-1:0]              cfg_wdata
);

    logic [HB_W-1:0] half_beta_reg;
    logic            push, pop;
    job_t            push_job, pop_job;
    q_status_t       q_status;

    // The user must write the configuration register only while the block is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_beta_reg <= HB_RESET;
        end
        else if (cfg_we)
        begin
            half_beta_reg <= cfg_wdata;
        end
    end

    // The front end tracks the active query and the fill count of the store.
    bse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .distance      (distance),
        .point_index   (point_index),
        .search_radius (search_radius),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    // Each job carries its own centre, so queries may overtake pending tests safely.
    bse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    // The tester runs the lune test on stored candidates in slot order until one blocks or is not nearer.
    bse_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .half_beta       (half_beta_reg),
        .q_status        (q_status),
        .pop_job         (pop_job),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .query_index     (query_index),
        .neighbour_index (neighbour_index)
    );

endmodule

// File: hw/rtl/bse_checker.sv
// Port-level checker for the edge filter, bound to the top level.
`timescale 1ns / 1ps
module bse_checker
    import bse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             kind,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [IDX_W-1:0] query_index,
    input  logic [IDX_W-1:0] neighbour_index
);

    // No edge is offered in the cycle after reset is applied.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

    // A query is never queued, so it cannot fill the queue.
    a_query_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !kind |=> in_ready)
        else $error("in_ready dropped after a query transfer");

    // A stalled edge keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(query_index)
        && $stable(neighbour_index))
        else $error("stalled edge changed");

endmodule

bind beta_skeleton_edge_filter bse_checker u_bse_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .query_index     (query_index),
    .neighbour_index (neighbour_index)
);

// File: tb/beta_skeleton_edge_filter_tb.sv
// Self-checking testbench for the beta-skeleton edge filter: directed and random queries.
`timescale 1ns / 1ps
module beta_skeleton_edge_filter_tb;
    import bse_pkg::*;

    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_CAND  = 1'b1;
    localparam int   IDLE_LIMIT = 20000;
    // Up to three jobs may still be in flight after the last edge, each scanning at worst
    // 63 stored entries; leave slack so a still-running test cannot race a config write.
    localparam int   DRAIN_CYCLES = 6000;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         kind = 1'b0;
    logic signed [COORD_BITS-1:0] pos_x = '0;
    logic signed [COORD_BITS-1:0] pos_y = '0;
    logic signed [COORD_BITS-1:0] pos_z = '0;
    logic [DIST_W-1:0]            distance = '0;
    logic [IDX_W-1:0]             point_index = '0;
    logic [DIST_W-1:0]            search_radius = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [IDX_W-1:0]             query_index;
    logic [IDX_W-1:0]             neighbour_index;
    logic                         cfg_we = 1'b0;
    logic [HB_W-1:0]              cfg_wdata = '0;

    beta_skeleton_edge_filter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .distance(distance), .point_index(point_index), .search_radius(search_radius),
        .out_valid(out_valid), .out_ready(out_ready),
        .query_index(query_index), .neighbour_index(neighbour_index),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #6 clk = ~clk;

    // Shadow state of the filter, kept at the widths of the block.
    logic [HB_W-1:0]   sh_half_beta;
    logic signed [COORD_BITS-1:0] sh_cx, sh_cy, sh_cz;
    logic [IDX_W-1:0]  sh_cid;
    logic [DIST_W-1:0] sh_radius;
    logic              sh_past;
    int                sh_count;
    logic signed [COORD_BITS-1:0] sh_x [MAX_CANDIDATES];
    logic signed [COORD_BITS-1:0] sh_y [MAX_CANDIDATES];
    logic signed [COORD_BITS-1:0] sh_z [MAX_CANDIDATES];
    logic [DIST_W-1:0] sh_d [MAX_CANDIDATES];

    // Edges predicted but not yet seen on the output.
    logic [IDX_W-1:0] edge_q_query [$];
    logic [IDX_W-1:0] edge_q_neigh [$];

    int mismatches = 0;
    int idle_cycles = 0;
    bit sender_busy = 1'b0;
    int burst_left = 0;
    int rx_mode = 0;

    // Squared offset from point k to the sphere centre a + hb*(b - a), the offset scaled by 2^15.
    function automatic logic [127:0] lune_sq(input logic signed [63:0] a[3],
                                             input logic signed [63:0] b[3],
                                             input logic signed [63:0] k[3]);
        logic [127:0] acc;
        logic signed [63:0] off;
        logic [63:0] mag;
        acc = '0;
        for (int i = 0; i < 3; i++)
        begin
            off = 64'sd32768 * (k[i] - a[i]) - $signed({48'd0, sh_half_beta}) * (b[i] - a[i]);
            mag = off[63] ? 64'(-off) : 64'(off);
            acc = acc + 128'(mag) * 128'(mag);
        end
        return acc;
    endfunction

    // Updates the shadow state for one accepted transfer and queues any edge.
    task automatic predict_edge(input logic k_in, input logic signed [COORD_BITS-1:0] x,
                                input logic signed [COORD_BITS-1:0] y,
                                input logic signed [COORD_BITS-1:0] z,
                                input logic [DIST_W-1:0] d, input logic [IDX_W-1:0] idx,
                                input logic [DIST_W-1:0] rad_in);
        logic signed [63:0] pi[3], pj[3], pk[3];
        logic [63:0] hd;
        logic [127:0] rad;
        bit blocked;
        if (k_in == KIND_QUERY)
        begin
            sh_cx = x; sh_cy = y; sh_cz = z;
            sh_cid = idx; sh_radius = rad_in;
            sh_past = 1'b0; sh_count = 0;
            return;
        end
        if (sh_past) return;
        if (d > sh_radius)
        begin
            sh_past = 1'b1;
            return;
        end
        if (sh_count >= MAX_CANDIDATES) return;
        pi[0] = sh_cx; pi[1] = sh_cy; pi[2] = sh_cz;
        pj[0] = x; pj[1] = y; pj[2] = z;
        hd = 64'(sh_half_beta) * 64'(d);
        rad = 128'(hd) * 128'(hd);
        blocked = 1'b0;
        for (int n = 0; n < sh_count; n++)
        begin
            if (sh_d[n] >= d) break;
            pk[0] = sh_x[n]; pk[1] = sh_y[n]; pk[2] = sh_z[n];
            if (lune_sq(pi, pj, pk) < rad && lune_sq(pj, pi, pk) < rad)
            begin
                blocked = 1'b1;
                break;
            end
        end
        sh_x[sh_count] = x; sh_y[sh_count] = y; sh_z[sh_count] = z; sh_d[sh_count] = d;
        sh_count++;
        if (!blocked)
        begin
            edge_q_query.push_back(sh_cid);
            edge_q_neigh.push_back(idx);
        end
    endtask

    // Sends one transfer. The sender runs in bursts; before three bursts in four it idles a random gap.
    // Within a burst in_valid stays high from one transfer to the next.
    task automatic send_item(input logic k_in, input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input logic signed [COORD_BITS-1:0] z,
                             input logic [DIST_W-1:0] d, input logic [IDX_W-1:0] idx,
                             input logic [DIST_W-1:0] rad_in);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        kind <= k_in; pos_x <= x; pos_y <= y; pos_z <= z;
        distance <= d; point_index <= idx; search_radius <= rad_in;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_edge(k_in, x, y, z, d, idx, rad_in);
        @(negedge clk);
    endtask

    // Stops sending, waits until every predicted edge has arrived, then lets the tester settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (edge_q_query.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Writes half_beta while the block is idle.
    task automatic write_half_beta(input logic [HB_W-1:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sh_half_beta = value;
    endtask

    function automatic logic signed [COORD_BITS-1:0] rnd_coord(input int spread);
        return COORD_BITS'($signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Directed: extremes of every field, stray candidates, radius cut-off, ties.
    task automatic test_directed();
        logic signed [COORD_BITS-1:0] cmax, cmin;
        cmax = {1'b0, {(COORD_BITS-1){1'b1}}};
        cmin = {1'b1, {(COORD_BITS-1){1'b0}}};
        // A candidate with no open query gives nothing.
        send_item(KIND_CAND, 0, 0, 0, 0, 32'h1, 0);
        send_item(KIND_QUERY, cmin, cmax, 0, '1, 32'hFFFF_FFFF, '1);
        send_item(KIND_CAND, cmax, cmin, cmin, 0, 32'h0, 0);
        send_item(KIND_CAND, cmax, cmax, cmax, 25'd100, 32'hAAAA_5555, '1);
        send_item(KIND_CAND, cmin, cmin, cmin, '1, 32'h5555_AAAA, 0);
        // Equal distances stop the scan.
        send_item(KIND_CAND, cmin, cmin, cmin, '1, 32'h7, 0);
        send_item(KIND_QUERY, 0, 0, 0, 0, 32'h10, 25'd1000);
        send_item(KIND_CAND, 24'sd256, 0, 0, 25'd256, 32'h11, 0);
        send_item(KIND_CAND, 24'sd512, 0, 0, 25'd512, 32'h12, 0);
        send_item(KIND_CAND, 24'sd300, 24'sd10, 0, 25'd300, 32'h13, 0);
        // Out of order distance.
        send_item(KIND_CAND, 0, 24'sd200, 0, 25'd200, 32'h14, 0);
        // Past the radius: this and the following candidate give nothing.
        send_item(KIND_CAND, 24'sd900, 0, 0, 25'd1001, 32'h15, 0);
        send_item(KIND_CAND, 24'sd1, 0, 0, 25'd1, 32'h16, 0);
        // Zero radius query.
        send_item(KIND_QUERY, 24'sd5, 24'sd5, 24'sd5, 0, 32'h20, 0);
        send_item(KIND_CAND, 24'sd5, 24'sd5, 24'sd5, 0, 32'h21, 0);
        send_item(KIND_CAND, 24'sd6, 24'sd5, 24'sd5, 25'd1, 32'h22, 0);
    endtask

    // One query with a cluster of candidates, mostly in rising distance order.
    task automatic send_query(input int n, input int spread);
        logic signed [COORD_BITS-1:0] cx, cy, cz;
        logic [DIST_W-1:0] d, rad;
        cx = rnd_coord(8000000); cy = rnd_coord(8000000); cz = rnd_coord(8000000);
        rad = ($urandom_range(0, 7) == 0) ? DIST_W'($urandom) : DIST_W'(spread * 2);
        send_item(KIND_QUERY, cx, cy, cz, DIST_W'($urandom), $urandom, rad);
        d = '0;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                d = DIST_W'($urandom);            // broken ordering or noise
            else
                d = d + DIST_W'($urandom_range(0, spread / 4 + 1));
            send_item(KIND_CAND, cx + rnd_coord(spread), cy + rnd_coord(spread),
                      cz + rnd_coord(spread), d, $urandom, DIST_W'($urandom));
        end
    endtask

    task automatic test_random(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
            send_query(n, $urandom_range(0, 3) == 0 ? 8000000 : $urandom_range(16, 4000));
            sent += n + 1;
            // Let the block run dry now and then.
            if ($urandom_range(0, 24) == 0)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
                while (edge_q_query.size() != 0) @(negedge clk);
            end
        end
    endtask

    // Receiver: stalls on a pattern of its own, with stretches of no stall.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Compares each edge with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (edge_q_query.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected edge %h -> %h", query_index, neighbour_index);
            end
            else
            begin
                if (query_index !== edge_q_query[0] || neighbour_index !== edge_q_neigh[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("edge mismatch: expected %h -> %h, got %h -> %h",
                                 edge_q_query[0], edge_q_neigh[0], query_index,
                                 neighbour_index);
                end
                void'(edge_q_query.pop_front());
                void'(edge_q_neigh.pop_front());
            end
        end
    end

    // Watchdog: counts cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !sender_busy)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        sh_half_beta = HB_RESET;
        sh_past = 1'b1; sh_count = 0;
        sh_cx = '0; sh_cy = '0; sh_cz = '0; sh_cid = '0; sh_radius = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        sender_busy = 1'b1;
        test_directed();
        write_half_beta(16'h4000);            // Gabriel graph
        test_directed();
        test_random(400);
        write_half_beta(16'h6000);
        test_random(400);
        write_half_beta(16'hFFFF);            // outside the usual range
        test_random(150);
        write_half_beta(16'h0000);
        test_random(100);
        write_half_beta(16'h8000);            // relative neighbourhood graph
        test_random(450);
        drain();
        sender_busy = 1'b0;
        if (mismatches == 0 && edge_q_query.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
